// ----- src/m3h_pkg.sv -----
// ----------------------------------------------------------------------------
// m3h_pkg
// Shared types, constants and helpers of the murmur3 32-bit hash core
// ----------------------------------------------------------------------------
package m3h_pkg;

    localparam logic [31:0] MIX_C1 = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2 = 32'h1b873593;
    localparam logic [31:0] MIX_C3 = 32'he6546b64;
    localparam logic [31:0] FIN_C4 = 32'h85ebca6b;
    localparam logic [31:0] FIN_C5 = 32'hc2b2ae35;

    localparam int M3H_QUEUE_DEPTH = 4;

    localparam logic [2:0] FULL_WORD_BYTES = 3'd4;

    // one scrambled word on its way from front end to back end
    typedef struct packed {
        logic [31:0] k;
        logic [2:0]  byte_count;
        logic        last;
    } m3h_item_t;

    // low 32 bits of a 32x32 product
    function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
        logic [63:0] p;
        p = 64'(a) * 64'(b);
        return p[31:0];
    endfunction

endpackage

// ----- src/m3h_front.sv -----
// ----------------------------------------------------------------------------
// m3h_front
// Input register, byte masking and two-stage k1 scramble
// ----------------------------------------------------------------------------
module m3h_front
    import m3h_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_key_word,
    input  logic [2:0]  s_byte_count,
    input  logic        s_last,
    input  logic        q_full,
    output logic        q_push,
    output m3h_item_t   q_item
);

    logic        a_valid_reg;
    logic [31:0] a_word_reg;
    logic [2:0]  a_count_reg;
    logic        a_last_reg;
    logic        b_valid_reg;
    logic [31:0] b_k_reg;
    logic [2:0]  b_count_reg;
    logic        b_last_reg;
    logic        adv;
    logic [2:0]  count_clamped;
    logic [31:0] word_masked;
    logic [31:0] b_rot;

    // whole pipe moves unless the last stage is blocked by a full queue
    assign adv     = !b_valid_reg || !q_full;
    assign s_ready = adv;
    assign q_push  = b_valid_reg && !q_full;

    always_comb begin
        count_clamped = (s_byte_count > FULL_WORD_BYTES) ? FULL_WORD_BYTES : s_byte_count;
        case (count_clamped)
            3'd1:    word_masked = {24'd0, s_key_word[7:0]};
            3'd2:    word_masked = {16'd0, s_key_word[15:0]};
            3'd3:    word_masked = {8'd0, s_key_word[23:0]};
            3'd4:    word_masked = s_key_word;
            default: word_masked = 32'd0;
        endcase
    end

    assign b_rot = {b_k_reg[16:0], b_k_reg[31:17]};

    always_comb begin
        q_item.k          = mul32(b_rot, MIX_C2);
        q_item.byte_count = b_count_reg;
        q_item.last       = b_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= s_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_word_reg  <= word_masked;
            a_count_reg <= count_clamped;
            a_last_reg  <= s_last;
            b_k_reg     <= mul32(a_word_reg, MIX_C1);
            b_count_reg <= a_count_reg;
            b_last_reg  <= a_last_reg;
        end
    end

endmodule

// ----- src/m3h_queue.sv -----
// ----------------------------------------------------------------------------
// m3h_queue
// Small FIFO of scrambled words between front end and back end
// ----------------------------------------------------------------------------
module m3h_queue
    import m3h_pkg::*;
#(
    parameter int QUEUE_DEPTH = M3H_QUEUE_DEPTH
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  m3h_item_t push_item,
    output logic      full,
    input  logic      pop,
    output logic      pop_valid,
    output m3h_item_t pop_item
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    m3h_item_t         entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     rd_ptr_reg;
    logic [CW-1:0]     cnt_reg;
    logic [CW-1:0]     cnt_next;
    logic              do_push;
    logic              do_pop;

    assign full      = (cnt_reg == CW'(QUEUE_DEPTH));
    assign pop_valid = (cnt_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    // front end must never push into a full queue
    assert property (@(posedge aclk) disable iff (!aresetn) push |-> !full)
        else $error("push into full queue");

    // occupancy grows by one on an accepted push without a pop
    assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && !do_pop) |=> (cnt_reg == $past(cnt_reg) + CW'(1)))
        else $error("queue count lost a push");

endmodule

// ----- src/m3h_back.sv -----
// ----------------------------------------------------------------------------
// m3h_back
// Running hash recurrence, length count, fmix32 finalizer and result register
// ----------------------------------------------------------------------------
module m3h_back
    import m3h_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [31:0] seed,
    input  logic        q_valid,
    input  m3h_item_t   q_item,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_hash
);

    localparam logic [1:0] ST_MIX  = 2'd0;
    localparam logic [1:0] ST_FIN1 = 2'd1;
    localparam logic [1:0] ST_FIN2 = 2'd2;

    logic [1:0]  state_reg;
    logic [1:0]  state_next;
    logic        in_key_reg;
    logic [31:0] h_reg;
    logic [31:0] len_reg;
    logic [31:0] mix_reg;
    logic [31:0] out_reg;
    logic        out_valid_reg;
    logic [31:0] h_base;
    logic [31:0] len_base;
    logic [31:0] hx;
    logic [31:0] hr;
    logic [31:0] h_new;
    logic [31:0] len_new;
    logic [31:0] fa;
    logic [31:0] fb;
    logic        load_out;

    assign q_pop    = (state_reg == ST_MIX) && q_valid;
    assign load_out = (state_reg == ST_FIN2) && (!out_valid_reg || m_ready);
    assign m_valid  = out_valid_reg;
    assign m_hash   = out_reg ^ (out_reg >> 16);

    always_comb begin
        h_base   = in_key_reg ? h_reg : seed;
        len_base = in_key_reg ? len_reg : 32'd0;
        hx       = h_base ^ q_item.k;
        hr       = {hx[18:0], hx[31:19]};
        if (q_item.byte_count == FULL_WORD_BYTES) begin
            h_new = hr + (hr << 2) + MIX_C3;
        end else begin
            h_new = hx;
        end
        len_new = len_base + 32'(q_item.byte_count);
        fa      = h_reg ^ len_reg;
        fa      = fa ^ (fa >> 16);
        fb      = mix_reg ^ (mix_reg >> 13);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_MIX: begin
                if (q_pop && q_item.last) begin
                    state_next = ST_FIN1;
                end
            end
            ST_FIN1: state_next = ST_FIN2;
            ST_FIN2: begin
                if (load_out) begin
                    state_next = ST_MIX;
                end
            end
            default: state_next = ST_MIX;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_MIX;
            in_key_reg    <= 1'b0;
            h_reg         <= 32'd0;
            len_reg       <= 32'd0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (q_pop) begin
                in_key_reg <= !q_item.last;
                h_reg      <= h_new;
                len_reg    <= len_new;
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FIN1) begin
            mix_reg <= mul32(fa, FIN_C4);
        end
        if (load_out) begin
            out_reg <= mul32(fb, FIN_C5);
        end
    end

    // finalizer stages never take a new word
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_MIX) |-> !q_pop)
        else $error("word popped during finalize");

    // a last word always leads into the finalizer
    assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_item.last) |=> (state_reg == ST_FIN1) && !in_key_reg)
        else $error("last word did not start finalize");

    // a pending result is not overwritten before it is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> out_valid_reg && $stable(out_reg))
        else $error("pending hash lost");

endmodule

// ----- src/murmur3_32_hash_core.sv -----
// ----------------------------------------------------------------------------
// murmur3_32_hash_core
// Streaming MurmurHash3 x86_32 over little-endian 32-bit key words
// ----------------------------------------------------------------------------
// Each request carries up to four key bytes (first byte in bits 7:0), a byte
// count and a last flag; the hash of the key appears as one result request on
// the m_ side after the word flagged last, and the next word starts a new key
// from the seed. A word is taken every cycle as long as the internal queue has
// room: the front end masks unused bytes, registers the word and runs the two
// k1 multiplies in two stages, and the back end folds one word per cycle into
// the running hash while it is in its mix state. A last word takes the back
// end on through the two fmix32 multiply stages, and no new word is taken
// until the hash is loaded into the result register, which waits while an
// earlier result is still pending. Seed writes take effect at the next key
// start and are meant to be made while the core is idle. There is no
// clearing pass after reset.
// ----------------------------------------------------------------------------
module murmur3_32_hash_core
    import m3h_pkg::*;
#(
    parameter int QUEUE_DEPTH = M3H_QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    // seed register write port
    input  logic        seed_wr_en,
    input  logic [31:0] seed_wr_data,
    // key word requests
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_key_word,
    input  logic [2:0]  s_byte_count,
    input  logic        s_last,
    // hash result requests
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_hash
);

    logic [31:0] seed_reg;
    logic        q_push;
    logic        q_full;
    logic        q_pop;
    logic        q_valid;
    m3h_item_t   q_push_item;
    m3h_item_t   q_pop_item;

    // seed register, reset to zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= 32'd0;
        end else if (seed_wr_en) begin
            seed_reg <= seed_wr_data;
        end
    end

    // front end: accept, mask, scramble
    m3h_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_key_word   (s_key_word),
        .s_byte_count (s_byte_count),
        .s_last       (s_last),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_item       (q_push_item)
    );

    // decouples scramble pipe from the hash recurrence
    m3h_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_item  (q_pop_item)
    );

    // back end: running hash, length, finalizer, result register
    m3h_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .seed    (seed_reg),
        .q_valid (q_valid),
        .q_item  (q_pop_item),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_hash  (m_hash)
    );

endmodule
